[hdl/qrs_pkg.sv]
`default_nettype none

package qrs_pkg;

    localparam int WORD_BITS   = 32;
    localparam int FRAC_BITS   = 16;
    localparam int RTOL_BITS   = 16;
    localparam int DISC_BITS   = 2 * WORD_BITS + 2;
    localparam int ROOT_BITS   = DISC_BITS / 2;
    localparam int SQREM_BITS  = ROOT_BITS + 4;
    localparam int NUM_BITS    = ROOT_BITS + 1;
    localparam int DIVN_BITS   = NUM_BITS + FRAC_BITS;
    localparam int DEN_BITS    = WORD_BITS + 1;
    localparam int DREM_BITS   = DEN_BITS + 1;

    localparam int DISC_STAGES = 3;
    localparam int SQRT_STAGES = ROOT_BITS;
    localparam int DIV_STAGES  = DIVN_BITS;
    localparam int LATENCY     = DISC_STAGES + SQRT_STAGES + 1 + DIV_STAGES + 1;

    localparam logic [DIVN_BITS-1:0] HALF_RANGE =
        {{(DIVN_BITS-1){1'b0}}, 1'b1} << (WORD_BITS - 1);

    typedef enum logic [1:0] {
        KIND_NONE     = 2'd0,
        KIND_DISTINCT = 2'd1,
        KIND_DOUBLE   = 2'd2,
        KIND_COMPLEX  = 2'd3
    } kind_t;

    typedef enum logic {
        REG_DISC_TOL = 1'b0,
        REG_ROOT_TOL = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic                        a_zero;
        kind_t                       kind;
        logic                        aneg;
        logic signed [WORD_BITS-1:0] b;
        logic [DEN_BITS-1:0]         den;
    } sol_side_t;

    typedef struct packed {
        logic [DISC_BITS-1:0]  rad;
        logic [SQREM_BITS-1:0] rem;
        logic [ROOT_BITS-1:0]  root;
    } sqrt_data_t;

    typedef struct packed {
        logic [DIVN_BITS-1:0] num;
        logic [DREM_BITS-1:0] rem;
    } div_data_t;

    typedef struct packed {
        logic  a_zero;
        kind_t kind;
        logic  neg;
    } div_side_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] value;
        logic                 sat;
    } fin_t;

    function automatic sqrt_data_t sqrt_step(input sqrt_data_t d);
        logic [SQREM_BITS-1:0] rem2;
        logic [SQREM_BITS-1:0] trial;
        sqrt_data_t            o;
        rem2  = {d.rem[SQREM_BITS-3:0], d.rad[DISC_BITS-1 -: 2]};
        trial = {{(SQREM_BITS-ROOT_BITS-2){1'b0}}, d.root, 2'b01};
        o.rad = {d.rad[DISC_BITS-3:0], 2'b00};
        if (rem2 >= trial)
        begin
            o.rem  = rem2 - trial;
            o.root = {d.root[ROOT_BITS-2:0], 1'b1};
        end
        else
        begin
            o.rem  = rem2;
            o.root = {d.root[ROOT_BITS-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic div_data_t div_step(input div_data_t d, input logic [DEN_BITS-1:0] den);
        logic [DREM_BITS-1:0] rem2;
        logic [DREM_BITS-1:0] dene;
        logic                 ge;
        div_data_t            o;
        rem2  = {d.rem[DREM_BITS-2:0], d.num[DIVN_BITS-1]};
        dene  = {1'b0, den};
        ge    = rem2 >= dene;
        o.num = {d.num[DIVN_BITS-2:0], ge};
        o.rem = ge ? rem2 - dene : rem2;
        return o;
    endfunction

    // Saturates the quotient to the word range, snaps small magnitudes and applies the sign.
    function automatic fin_t finish_root(input logic [DIVN_BITS-1:0] q, input logic neg,
                                         input logic [RTOL_BITS-1:0] rtol);
        logic [DIVN_BITS-1:0] lim;
        logic [DIVN_BITS-1:0] qs;
        fin_t                 o;
        lim   = neg ? HALF_RANGE : HALF_RANGE - {{(DIVN_BITS-1){1'b0}}, 1'b1};
        o.sat = q > lim;
        qs    = o.sat ? lim : q;
        if (qs < {{(DIVN_BITS-RTOL_BITS){1'b0}}, rtol})
        begin
            qs = '0;
        end
        o.value = neg ? (~qs[WORD_BITS-1:0] + {{(WORD_BITS-1){1'b0}}, 1'b1}) : qs[WORD_BITS-1:0];
        return o;
    endfunction

endpackage

`default_nettype wire

[hdl/qrs_disc.sv]
`default_nettype none

module qrs_disc (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    input  wire logic signed [qrs_pkg::WORD_BITS-1:0] coef_a,
    input  wire logic signed [qrs_pkg::WORD_BITS-1:0] coef_b,
    input  wire logic signed [qrs_pkg::WORD_BITS-1:0] coef_c,
    input  wire logic [qrs_pkg::WORD_BITS-1:0]        disc_tol,
    output logic                                      out_valid,
    output qrs_pkg::sqrt_data_t                       out_data,
    output qrs_pkg::sol_side_t                        out_side
);

    logic                                 v1_reg, v2_reg, v3_reg;
    logic [qrs_pkg::WORD_BITS-1:0]        amag_reg, bmag_reg, cmag_reg;
    logic                                 aneg_reg, a_zero_reg, ac_pos_reg;
    logic signed [qrs_pkg::WORD_BITS-1:0] b_reg;

    logic [2*qrs_pkg::WORD_BITS-1:0]      b2_reg, ac_reg;
    logic [qrs_pkg::WORD_BITS-1:0]        amag2_reg;
    logic                                 aneg2_reg, a_zero2_reg, ac_pos2_reg;
    logic signed [qrs_pkg::WORD_BITS-1:0] b2s_reg;

    qrs_pkg::sqrt_data_t data_reg, data_next;
    qrs_pkg::sol_side_t  side_reg, side_next;

    logic [qrs_pkg::DISC_BITS-1:0] b2e, ac4, mag;
    logic                          dneg, big;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        amag_reg   <= coef_a[qrs_pkg::WORD_BITS-1] ? -coef_a : coef_a;
        bmag_reg   <= coef_b[qrs_pkg::WORD_BITS-1] ? -coef_b : coef_b;
        cmag_reg   <= coef_c[qrs_pkg::WORD_BITS-1] ? -coef_c : coef_c;
        aneg_reg   <= coef_a[qrs_pkg::WORD_BITS-1];
        a_zero_reg <= coef_a == '0;
        ac_pos_reg <= (coef_c != '0)
                      && (coef_a[qrs_pkg::WORD_BITS-1] == coef_c[qrs_pkg::WORD_BITS-1]);
        b_reg      <= coef_b;

        b2_reg      <= bmag_reg * bmag_reg;
        ac_reg      <= amag_reg * cmag_reg;
        amag2_reg   <= amag_reg;
        aneg2_reg   <= aneg_reg;
        a_zero2_reg <= a_zero_reg;
        ac_pos2_reg <= ac_pos_reg;
        b2s_reg     <= b_reg;

        data_reg <= data_next;
        side_reg <= side_next;
    end

    always_comb
    begin
        b2e  = {2'b00, b2_reg};
        ac4  = {ac_reg, 2'b00};
        dneg = ac_pos2_reg && (ac4 > b2e);
        if (!ac_pos2_reg)
        begin
            mag = b2e + ac4;
        end
        else if (dneg)
        begin
            mag = ac4 - b2e;
        end
        else
        begin
            mag = b2e - ac4;
        end
        big = mag >= {{(qrs_pkg::DISC_BITS-qrs_pkg::WORD_BITS){1'b0}}, disc_tol};

        data_next.rad  = mag;
        data_next.rem  = '0;
        data_next.root = '0;

        side_next.a_zero = a_zero2_reg;
        side_next.aneg   = aneg2_reg;
        side_next.b      = b2s_reg;
        side_next.den    = {amag2_reg, 1'b0};
        priority if (a_zero2_reg)
        begin
            side_next.kind = qrs_pkg::KIND_NONE;
        end
        else if (big && !dneg)
        begin
            side_next.kind = qrs_pkg::KIND_DISTINCT;
        end
        else if (big)
        begin
            side_next.kind = qrs_pkg::KIND_COMPLEX;
        end
        else
        begin
            side_next.kind = qrs_pkg::KIND_DOUBLE;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = data_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

[hdl/qrs_sqrt.sv]
`default_nettype none

module qrs_sqrt (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire qrs_pkg::sqrt_data_t           in_data,
    input  wire qrs_pkg::sol_side_t            in_side,
    output logic                               out_valid,
    output logic [qrs_pkg::ROOT_BITS-1:0]      out_root,
    output qrs_pkg::sol_side_t                 out_side
);

    qrs_pkg::sqrt_data_t data_reg [qrs_pkg::SQRT_STAGES];
    qrs_pkg::sqrt_data_t data_in  [qrs_pkg::SQRT_STAGES];
    qrs_pkg::sol_side_t  side_reg [qrs_pkg::SQRT_STAGES];
    qrs_pkg::sol_side_t  side_in  [qrs_pkg::SQRT_STAGES];
    logic                vld_reg  [qrs_pkg::SQRT_STAGES];
    logic                vld_in   [qrs_pkg::SQRT_STAGES];

    for (genvar k = 0; k < qrs_pkg::SQRT_STAGES; k++)
    begin : g_stage
        if (k == 0)
        begin : g_head
            assign data_in[k] = in_data;
            assign side_in[k] = in_side;
            assign vld_in[k]  = in_valid;
        end
        else
        begin : g_body
            assign data_in[k] = data_reg[k-1];
            assign side_in[k] = side_reg[k-1];
            assign vld_in[k]  = vld_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_in[k];
            end
        end

        always_ff @(posedge clk)
        begin
            data_reg[k] <= qrs_pkg::sqrt_step(data_in[k]);
            side_reg[k] <= side_in[k];
        end
    end

    assign out_valid = vld_reg[qrs_pkg::SQRT_STAGES-1];
    assign out_root  = data_reg[qrs_pkg::SQRT_STAGES-1].root;
    assign out_side  = side_reg[qrs_pkg::SQRT_STAGES-1];

endmodule

`default_nettype wire

[hdl/qrs_div.sv]
`default_nettype none

module qrs_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic [qrs_pkg::NUM_BITS-1:0]  in_num,
    input  wire logic [qrs_pkg::DEN_BITS-1:0]  in_den,
    input  wire qrs_pkg::div_side_t            in_side,
    output logic                               out_valid,
    output logic [qrs_pkg::DIVN_BITS-1:0]      out_quot,
    output qrs_pkg::div_side_t                 out_side
);

    qrs_pkg::div_data_t            data_reg [qrs_pkg::DIV_STAGES];
    qrs_pkg::div_data_t            data_in  [qrs_pkg::DIV_STAGES];
    logic [qrs_pkg::DEN_BITS-1:0]  den_reg  [qrs_pkg::DIV_STAGES];
    logic [qrs_pkg::DEN_BITS-1:0]  den_in   [qrs_pkg::DIV_STAGES];
    qrs_pkg::div_side_t            side_reg [qrs_pkg::DIV_STAGES];
    qrs_pkg::div_side_t            side_in  [qrs_pkg::DIV_STAGES];
    logic                          vld_reg  [qrs_pkg::DIV_STAGES];
    logic                          vld_in   [qrs_pkg::DIV_STAGES];

    for (genvar k = 0; k < qrs_pkg::DIV_STAGES; k++)
    begin : g_stage
        if (k == 0)
        begin : g_head
            assign data_in[k].num = {in_num, {qrs_pkg::FRAC_BITS{1'b0}}};
            assign data_in[k].rem = '0;
            assign den_in[k]      = in_den;
            assign side_in[k]     = in_side;
            assign vld_in[k]      = in_valid;
        end
        else
        begin : g_body
            assign data_in[k] = data_reg[k-1];
            assign den_in[k]  = den_reg[k-1];
            assign side_in[k] = side_reg[k-1];
            assign vld_in[k]  = vld_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_in[k];
            end
        end

        always_ff @(posedge clk)
        begin
            data_reg[k] <= qrs_pkg::div_step(data_in[k], den_in[k]);
            den_reg[k]  <= den_in[k];
            side_reg[k] <= side_in[k];
        end
    end

    assign out_valid = vld_reg[qrs_pkg::DIV_STAGES-1];
    assign out_quot  = data_reg[qrs_pkg::DIV_STAGES-1].num;
    assign out_side  = side_reg[qrs_pkg::DIV_STAGES-1];

endmodule

`default_nettype wire

[hdl/quadratic_root_solver_core.sv]
// Solves a*x^2 + b*x + c = 0 for signed Q16.16 coefficients and takes a new item in every
// cycle: busy is never raised. Each item gives exactly one result, with done high for one
// cycle, after it has passed the 3-stage discriminant unit, the 33-stage square root
// pipeline (one root bit a stage), one stage that forms the numerators, the 50-stage
// dividers (one quotient bit a stage) and the output register. Results leave in the order
// the items came in and cannot be held off by the receiver.
`default_nettype none

module quadratic_root_solver_core (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic signed [qrs_pkg::WORD_BITS-1:0] coef_a,
    input  wire logic signed [qrs_pkg::WORD_BITS-1:0] coef_b,
    input  wire logic signed [qrs_pkg::WORD_BITS-1:0] coef_c,
    input  wire logic                                 write_enable,
    input  wire logic                                 reg_index,
    input  wire logic [qrs_pkg::WORD_BITS-1:0]        write_data,
    output logic                                      done,
    output logic [1:0]                                root_kind,
    output logic signed [qrs_pkg::WORD_BITS-1:0]      first_value,
    output logic signed [qrs_pkg::WORD_BITS-1:0]      second_value,
    output logic                                      overflowed
);

    logic [qrs_pkg::WORD_BITS-1:0] disc_tol_reg;
    logic [qrs_pkg::RTOL_BITS-1:0] root_tol_reg;

    logic                          disc_valid;
    qrs_pkg::sqrt_data_t           disc_data;
    qrs_pkg::sol_side_t            disc_side;

    logic                          sqrt_valid;
    logic [qrs_pkg::ROOT_BITS-1:0] sqrt_root;
    qrs_pkg::sol_side_t            sqrt_side;

    logic                          prep_valid_reg;
    logic [qrs_pkg::NUM_BITS-1:0]  num1_reg, num1_next, num2_reg, num2_next;
    logic [qrs_pkg::DEN_BITS-1:0]  den_reg;
    qrs_pkg::div_side_t            side1_reg, side1_next, side2_reg, side2_next;

    logic signed [qrs_pkg::NUM_BITS:0] neg_b, root_ext, n1, n2;

    logic                           div1_valid, div2_valid;
    logic [qrs_pkg::DIVN_BITS-1:0]  quot1, quot2;
    qrs_pkg::div_side_t             dside1, dside2;
    qrs_pkg::fin_t                  fin1, fin2;

    logic                           done_reg;
    qrs_pkg::kind_t                 kind_reg, kind_next;
    logic [qrs_pkg::WORD_BITS-1:0]  first_reg, first_next, second_reg, second_next;
    logic                           ovf_reg, ovf_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disc_tol_reg <= qrs_pkg::WORD_BITS'(4295);
            root_tol_reg <= qrs_pkg::RTOL_BITS'(1);
        end
        else if (write_enable)
        begin
            unique case (qrs_pkg::reg_index_t'(reg_index))
                qrs_pkg::REG_DISC_TOL: disc_tol_reg <= write_data;
                qrs_pkg::REG_ROOT_TOL: root_tol_reg <= write_data[qrs_pkg::RTOL_BITS-1:0];
                default:               disc_tol_reg <= disc_tol_reg;
            endcase
        end
    end

    qrs_disc u_disc (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .coef_a    (coef_a),
        .coef_b    (coef_b),
        .coef_c    (coef_c),
        .disc_tol  (disc_tol_reg),
        .out_valid (disc_valid),
        .out_data  (disc_data),
        .out_side  (disc_side)
    );

    qrs_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (disc_valid),
        .in_data   (disc_data),
        .in_side   (disc_side),
        .out_valid (sqrt_valid),
        .out_root  (sqrt_root),
        .out_side  (sqrt_side)
    );

    always_comb
    begin
        neg_b    = -{{(qrs_pkg::NUM_BITS+1-qrs_pkg::WORD_BITS){sqrt_side.b[qrs_pkg::WORD_BITS-1]}},
                     sqrt_side.b};
        root_ext = {2'b00, sqrt_root};
        unique case (sqrt_side.kind)
            qrs_pkg::KIND_DISTINCT:
            begin
                n1 = neg_b + root_ext;
                n2 = neg_b - root_ext;
            end
            qrs_pkg::KIND_COMPLEX:
            begin
                n1 = neg_b;
                n2 = root_ext;
            end
            default:
            begin
                n1 = neg_b;
                n2 = neg_b;
            end
        endcase
        num1_next = n1[qrs_pkg::NUM_BITS] ? -n1[qrs_pkg::NUM_BITS-1:0] : n1[qrs_pkg::NUM_BITS-1:0];
        num2_next = n2[qrs_pkg::NUM_BITS] ? -n2[qrs_pkg::NUM_BITS-1:0] : n2[qrs_pkg::NUM_BITS-1:0];

        side1_next.a_zero = sqrt_side.a_zero;
        side1_next.kind   = sqrt_side.kind;
        side1_next.neg    = n1[qrs_pkg::NUM_BITS] ^ sqrt_side.aneg;
        side2_next.a_zero = sqrt_side.a_zero;
        side2_next.kind   = sqrt_side.kind;
        side2_next.neg    = (sqrt_side.kind == qrs_pkg::KIND_COMPLEX)
                            ? 1'b0 : (n2[qrs_pkg::NUM_BITS] ^ sqrt_side.aneg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else
        begin
            prep_valid_reg <= sqrt_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        num1_reg  <= num1_next;
        num2_reg  <= num2_next;
        den_reg   <= sqrt_side.den;
        side1_reg <= side1_next;
        side2_reg <= side2_next;
    end

    qrs_div u_div_first (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid_reg),
        .in_num    (num1_reg),
        .in_den    (den_reg),
        .in_side   (side1_reg),
        .out_valid (div1_valid),
        .out_quot  (quot1),
        .out_side  (dside1)
    );

    qrs_div u_div_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid_reg),
        .in_num    (num2_reg),
        .in_den    (den_reg),
        .in_side   (side2_reg),
        .out_valid (div2_valid),
        .out_quot  (quot2),
        .out_side  (dside2)
    );

    always_comb
    begin
        fin1 = qrs_pkg::finish_root(quot1, dside1.neg, root_tol_reg);
        fin2 = qrs_pkg::finish_root(quot2, dside2.neg, root_tol_reg);
        kind_next = dside1.kind;
        if (dside1.a_zero)
        begin
            first_next  = '0;
            second_next = '0;
            ovf_next    = 1'b0;
        end
        else
        begin
            first_next  = fin1.value;
            second_next = fin2.value;
            ovf_next    = fin1.sat | fin2.sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div1_valid & div2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        first_reg  <= first_next;
        second_reg <= second_next;
        ovf_reg    <= ovf_next;
    end

    assign busy         = 1'b0;
    assign done         = done_reg;
    assign root_kind    = kind_reg;
    assign first_value  = first_reg;
    assign second_value = second_reg;
    assign overflowed   = ovf_reg;

endmodule

`default_nettype wire

[hdl/qrs_checker.sv]
`default_nettype none

module qrs_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 start,
    input wire logic                                 busy,
    input wire logic signed [qrs_pkg::WORD_BITS-1:0] coef_a,
    input wire logic signed [qrs_pkg::WORD_BITS-1:0] coef_b,
    input wire logic signed [qrs_pkg::WORD_BITS-1:0] coef_c,
    input wire logic                                 write_enable,
    input wire logic                                 reg_index,
    input wire logic [qrs_pkg::WORD_BITS-1:0]        write_data,
    input wire logic                                 done,
    input wire logic [1:0]                           root_kind,
    input wire logic signed [qrs_pkg::WORD_BITS-1:0] first_value,
    input wire logic signed [qrs_pkg::WORD_BITS-1:0] second_value,
    input wire logic                                 overflowed
);

    // Every result must trace back to an item taken a fixed latency earlier.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, qrs_pkg::LATENCY))
        else $error("result without a matching item");

    a_not_quadratic: assert property (@(posedge clk) disable iff (!rst_n)
        (done && root_kind == qrs_pkg::KIND_NONE)
        |-> (first_value == '0 && second_value == '0 && !overflowed))
        else $error("non-quadratic result is not all zero");

    a_double_root: assert property (@(posedge clk) disable iff (!rst_n)
        (done && root_kind == qrs_pkg::KIND_DOUBLE) |-> (first_value == second_value))
        else $error("double root values differ");

    a_imag_positive: assert property (@(posedge clk) disable iff (!rst_n)
        (done && root_kind == qrs_pkg::KIND_COMPLEX)
        |-> !second_value[qrs_pkg::WORD_BITS-1])
        else $error("imaginary magnitude is negative");

endmodule

bind quadratic_root_solver_core qrs_checker u_qrs_checker (.*);

`default_nettype wire

[dv/quadratic_root_solver_core_tb.sv]
`timescale 1ns / 100ps

module quadratic_root_solver_core_tb;

    import qrs_pkg::*;

    typedef struct packed {
        kind_t                kind;
        logic [WORD_BITS-1:0] first_val;
        logic [WORD_BITS-1:0] second_val;
        logic                 ovf;
    } roots_t;

    class solver_board;
        roots_t pending[$];
        int     mismatches;
        int     checked;

        function void note_item(roots_t r);
            pending.push_back(r);
        endfunction

        function void check_result(roots_t got);
            roots_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Result with nothing pending: %p", got);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.kind !== want.kind || got.first_val !== want.first_val
                || got.second_val !== want.second_val || got.ovf !== want.ovf)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected kind %0d x1 %h x2 %h ovf %b, got kind %0d x1 %h x2 %h ovf %b",
                             want.kind, want.first_val, want.second_val, want.ovf,
                             got.kind, got.first_val, got.second_val, got.ovf);
            end
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic signed [WORD_BITS-1:0] coef_a;
    logic signed [WORD_BITS-1:0] coef_b;
    logic signed [WORD_BITS-1:0] coef_c;
    logic                        write_enable;
    logic                        reg_index;
    logic [WORD_BITS-1:0]        write_data;
    logic                        done;
    logic [1:0]                  root_kind;
    logic signed [WORD_BITS-1:0] first_value;
    logic signed [WORD_BITS-1:0] second_value;
    logic                        overflowed;

    logic [31:0]     disc_tol;
    logic [15:0]     root_tol;
    solver_board     board = new();
    int              cycles;
    int              idle_pct;
    int              sent;
    localparam int   CYCLE_LIMIT = 400000;

    quadratic_root_solver_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .coef_a       (coef_a),
        .coef_b       (coef_b),
        .coef_c       (coef_c),
        .write_enable (write_enable),
        .reg_index    (reg_index),
        .write_data   (write_data),
        .done         (done),
        .root_kind    (root_kind),
        .first_value  (first_value),
        .second_value (second_value),
        .overflowed   (overflowed)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [WORD_BITS-1:0] scaled_quotient(longint num, longint unsigned den,
                                                             bit den_neg, logic [15:0] rtol,
                                                             inout bit ovf);
        bit              neg;
        longint unsigned q;
        longint unsigned lim;
        neg = (num < 0) != den_neg;
        q   = ((num < 0 ? longint'(-num) : num) << FRAC_BITS) / den;
        lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
        if (q > lim)
        begin
            q   = lim;
            ovf = 1'b1;
        end
        if (q < rtol)
            q = 0;
        return neg ? WORD_BITS'(-q) : WORD_BITS'(q);
    endfunction

    function automatic roots_t solve_quadratic(logic signed [31:0] a, logic signed [31:0] b,
                                               logic signed [31:0] c, logic [31:0] dtol,
                                               logic [15:0] rtol);
        logic signed [95:0] disc;
        logic [127:0]       mag_d;
        logic [127:0]       trial;
        logic [127:0]       root;
        longint unsigned    den;
        bit                 ovf;
        roots_t             r;
        r   = '0;
        ovf = 1'b0;
        if (a == 0)
            return r;
        disc  = 96'(b) * 96'(b) - 96'sd4 * 96'(a) * 96'(c);
        mag_d = disc < 0 ? 128'(-disc) : 128'(disc);
        root  = '0;
        for (int i = 34; i >= 0; i--)
        begin
            trial = root | (128'd1 << i);
            if (trial * trial <= mag_d)
                root = trial;
        end
        den = 2 * (a < 0 ? longint'(-longint'(a)) : longint'(a));
        if (mag_d >= dtol && disc >= 0)
        begin
            r.kind       = KIND_DISTINCT;
            r.first_val  = scaled_quotient(-longint'(b) + longint'(root), den, a < 0, rtol, ovf);
            r.second_val = scaled_quotient(-longint'(b) - longint'(root), den, a < 0, rtol, ovf);
        end
        else if (mag_d >= dtol)
        begin
            r.kind       = KIND_COMPLEX;
            r.first_val  = scaled_quotient(-longint'(b), den, a < 0, rtol, ovf);
            r.second_val = scaled_quotient(longint'(root), den, 1'b0, rtol, ovf);
        end
        else
        begin
            r.kind       = KIND_DOUBLE;
            r.first_val  = scaled_quotient(-longint'(b), den, a < 0, rtol, ovf);
            r.second_val = r.first_val;
        end
        r.ovf = ovf;
        return r;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        if (rst_n && done)
            board.check_result({kind_t'(root_kind), first_value, second_value, overflowed});
    end

    task automatic send_item(logic [31:0] a, logic [31:0] b, logic [31:0] c);
        start  <= 1'b1;
        coef_a <= a;
        coef_b <= b;
        coef_c <= c;
        do
            @(posedge clk);
        while (busy);
        board.note_item(solve_quadratic(a, b, c, disc_tol, root_tol));
        sent++;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic write_reg(reg_index_t idx, logic [31:0] value);
        write_enable <= 1'b1;
        reg_index    <= idx;
        write_data   <= value;
        @(posedge clk);
        write_enable <= 1'b0;
        if (idx == REG_DISC_TOL)
            disc_tol = value;
        else
            root_tol = value[15:0];
        @(posedge clk);
    endtask

    task automatic drain;
        start <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic send_random;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [63:0] cw;
        a = $urandom;
        b = $urandom;
        c = $urandom;
        case ($urandom_range(9))
            0:       a = 0;
            1, 2:
            begin
                a = $signed($urandom_range(0, 2 ** 21)) - 2 ** 20;
                b = $signed($urandom_range(0, 2 ** 23)) - 2 ** 22;
                c = $signed($urandom_range(0, 2 ** 23)) - 2 ** 22;
            end
            3, 4:
            begin
                a = $signed($urandom_range(1, 2 ** 20)) * ($urandom_range(1) ? 1 : -1);
                b = $signed($urandom_range(0, 2 ** 24)) - 2 ** 23;
                cw = (64'(b) * 64'(b)) / (64'sd4 * 64'(a));
                c = cw[31:0] + $signed($urandom_range(0, 2)) - 1;
            end
            5:       a = $signed($urandom_range(1, 8)) * ($urandom_range(1) ? 1 : -1);
            default: ;
        endcase
        send_item(a, b, c);
    endtask

    task automatic run_phase(int count);
        repeat (count) send_random();
        drain();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        coef_a       = '0;
        coef_b       = '0;
        coef_c       = '0;
        write_enable = 1'b0;
        reg_index    = REG_DISC_TOL;
        write_data   = '0;
        cycles       = 0;
        sent         = 0;
        disc_tol     = 32'd4295;
        root_tol     = 16'd1;
        idle_pct     = 11;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(32'h0, 32'h7fff_ffff, 32'h8000_0000);
        send_item(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
        send_item(32'h0001_0000, 32'h0, 32'h0001_0000);
        send_item(32'h0001_0000, 32'h0, 32'hffff_0000);
        send_item(32'hffff_0000, 32'h0003_0000, 32'h0002_0000);
        send_item(32'h0000_0001, 32'h7fff_ffff, 32'h0000_0001);
        send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_item(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_item(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        send_item(32'h0000_0001, 32'h0, 32'h8000_0000);
        send_item(32'h0000_0001, 32'h0, 32'h7fff_ffff);
        send_item(32'h7fff_ffff, 32'h0000_0001, 32'h0);
        send_item(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_item(32'h0001_0000, 32'h0000_0002, 32'h0000_0001);
        send_item(32'h0001_0000, 32'h0, 32'h0);
        drain();

        write_reg(REG_DISC_TOL, 32'd0);
        write_reg(REG_ROOT_TOL, 32'd0);
        send_item(32'h0001_0000, 32'h0, 32'h0);
        send_item(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
        send_item(32'h0000_0001, 32'h0, 32'h0000_0001);
        drain();

        write_reg(REG_DISC_TOL, 32'd1);
        run_phase(550);
        write_reg(REG_DISC_TOL, 32'hffff_ffff);
        write_reg(REG_ROOT_TOL, 32'h0000_ffff);
        idle_pct = 49;
        run_phase(550);
        write_reg(REG_DISC_TOL, $urandom);
        write_reg(REG_ROOT_TOL, $urandom_range(0, 300));
        idle_pct = 0;
        run_phase(630);

        $display("Sent %0d coefficient sets and checked %0d results over five tolerance settings.",
                 sent, board.checked);
        $display("Mismatches: %0d, results still pending: %0d.",
                 board.mismatches, board.pending.size());
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
hdl/qrs_pkg.sv
hdl/qrs_disc.sv
hdl/qrs_sqrt.sv
hdl/qrs_div.sv
hdl/quadratic_root_solver_core.sv
hdl/qrs_checker.sv
dv/quadratic_root_solver_core_tb.sv
